>>> hdl/pppenc_pkg.sv
// Shared types, constants and functions for the PPP async HDLC frame encoder.
// Used by the front end, back end and top level of the encoder; depends on nothing else.
package pppenc_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [7:0]  ADDR_BYTE  = 8'hFF;
    localparam logic [7:0]  CTRL_BYTE  = 8'h03;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    typedef enum logic [3:0] {
        T_IDLE,
        T_FLAG_OPEN,
        T_ADDR,
        T_CTRL,
        T_PROTO_HI,
        T_PROTO_LO,
        T_PAYLOAD,
        T_FCS_LO,
        T_FCS_HI,
        T_FLAG_CLOSE
    } token_t;

    typedef struct packed {
        logic        opens;
        logic        has_data;
        logic        closes;
        logic [7:0]  data_byte;
        logic [15:0] protocol;
    } cmd_t;

    typedef struct packed {
        logic       end_of_run;
        logic [7:0] line_byte;
    } out_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b < ESC_XOR) || (b == ESC_BYTE) || (b == FLAG_BYTE);
    endfunction

endpackage

>>> hdl/pppenc_fifo.sv
// Small first-in first-out queue held in flip-flops, with show-ahead read.
// Generic in width and depth; depends on nothing else.
module pppenc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/pppenc_front.sv
// Front end of the encoder: accepts input requests and marks whether each opens a frame,
// carries data and closes a frame. Depends on pppenc_pkg.
module pppenc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        payload_byte,
    input  logic [15:0]       protocol,
    input  logic              last_byte,
    input  logic              empty_frame,
    input  logic              cmd_full,
    output logic              cmd_push,
    output pppenc_pkg::cmd_t  cmd
);

    logic inside_reg, inside_next;

    assign cmd_push       = push && !cmd_full;
    assign cmd.opens      = !inside_reg;
    assign cmd.has_data   = !empty_frame;
    assign cmd.closes     = empty_frame || last_byte;
    assign cmd.data_byte  = payload_byte;
    assign cmd.protocol   = protocol;

    always_comb
    begin
        inside_next = inside_reg;
        if (cmd_push)
        begin
            inside_next = !cmd.closes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
        end
    end

endmodule

>>> hdl/pppenc_back.sv
// Back end of the encoder: walks the byte sequence of each classified request,
// escapes bytes, keeps the FCS and emits one line byte a cycle while the result queue has room. Uses pppenc_pkg.
module pppenc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  pppenc_pkg::cmd_t  cmd,
    output logic              cmd_pop,
    input  logic              out_full,
    output logic              out_push,
    output pppenc_pkg::out_t  out_data
);

    pppenc_pkg::token_t token_reg, token_next;
    pppenc_pkg::token_t token_after;
    pppenc_pkg::token_t token_first;
    pppenc_pkg::cmd_t   cmd_reg, cmd_next;
    logic               esc_reg, esc_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         cur_byte;
    logic               is_flag;
    logic               first_half;
    logic               advance;
    logic               tok_done;
    logic               last_tok;
    logic               load;

    always_comb
    begin
        case (token_reg)
            pppenc_pkg::T_FLAG_OPEN:  cur_byte = pppenc_pkg::FLAG_BYTE;
            pppenc_pkg::T_ADDR:       cur_byte = pppenc_pkg::ADDR_BYTE;
            pppenc_pkg::T_CTRL:       cur_byte = pppenc_pkg::CTRL_BYTE;
            pppenc_pkg::T_PROTO_HI:   cur_byte = cmd_reg.protocol[15:8];
            pppenc_pkg::T_PROTO_LO:   cur_byte = cmd_reg.protocol[7:0];
            pppenc_pkg::T_PAYLOAD:    cur_byte = cmd_reg.data_byte;
            pppenc_pkg::T_FCS_LO:     cur_byte = ~crc_reg[7:0];
            pppenc_pkg::T_FCS_HI:     cur_byte = ~crc_reg[15:8];
            pppenc_pkg::T_FLAG_CLOSE: cur_byte = pppenc_pkg::FLAG_BYTE;
            default:                  cur_byte = pppenc_pkg::FLAG_BYTE;
        endcase
    end

    always_comb
    begin
        case (token_reg)
            pppenc_pkg::T_FLAG_OPEN: token_after = pppenc_pkg::T_ADDR;
            pppenc_pkg::T_ADDR:      token_after = pppenc_pkg::T_CTRL;
            pppenc_pkg::T_CTRL:      token_after = pppenc_pkg::T_PROTO_HI;
            pppenc_pkg::T_PROTO_HI:  token_after = pppenc_pkg::T_PROTO_LO;
            pppenc_pkg::T_PROTO_LO:
            begin
                if (cmd_reg.has_data)
                begin
                    token_after = pppenc_pkg::T_PAYLOAD;
                end
                else if (cmd_reg.closes)
                begin
                    token_after = pppenc_pkg::T_FCS_LO;
                end
                else
                begin
                    token_after = pppenc_pkg::T_IDLE;
                end
            end
            pppenc_pkg::T_PAYLOAD:
            begin
                token_after = cmd_reg.closes ? pppenc_pkg::T_FCS_LO : pppenc_pkg::T_IDLE;
            end
            pppenc_pkg::T_FCS_LO:    token_after = pppenc_pkg::T_FCS_HI;
            pppenc_pkg::T_FCS_HI:    token_after = pppenc_pkg::T_FLAG_CLOSE;
            default:                 token_after = pppenc_pkg::T_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.opens)
        begin
            token_first = pppenc_pkg::T_FLAG_OPEN;
        end
        else if (cmd.has_data)
        begin
            token_first = pppenc_pkg::T_PAYLOAD;
        end
        else
        begin
            token_first = pppenc_pkg::T_FCS_LO;
        end
    end

    assign is_flag    = (token_reg == pppenc_pkg::T_FLAG_OPEN) ||
                        (token_reg == pppenc_pkg::T_FLAG_CLOSE);
    assign first_half = !is_flag && !esc_reg && pppenc_pkg::needs_escape(cur_byte);
    assign advance    = (token_reg != pppenc_pkg::T_IDLE) && !out_full;
    assign tok_done   = advance && !first_half;
    assign last_tok   = (token_after == pppenc_pkg::T_IDLE);
    assign load       = (token_reg == pppenc_pkg::T_IDLE) || (tok_done && last_tok);

    // Next state.
    always_comb
    begin
        token_next = token_reg;
        cmd_next   = cmd_reg;
        esc_next   = esc_reg;
        crc_next   = crc_reg;
        if (advance && first_half)
        begin
            esc_next = 1'b1;
        end
        if (tok_done)
        begin
            esc_next = 1'b0;
            case (token_reg)
                pppenc_pkg::T_FLAG_OPEN,
                pppenc_pkg::T_FLAG_CLOSE: crc_next = pppenc_pkg::CRC_INIT;
                pppenc_pkg::T_ADDR,
                pppenc_pkg::T_CTRL,
                pppenc_pkg::T_PROTO_HI,
                pppenc_pkg::T_PROTO_LO,
                pppenc_pkg::T_PAYLOAD:    crc_next = pppenc_pkg::crc_byte(crc_reg, cur_byte);
                default:                  crc_next = crc_reg;
            endcase
            token_next = token_after;
        end
        if (load)
        begin
            if (!cmd_empty)
            begin
                token_next = token_first;
                cmd_next   = cmd;
            end
            else
            begin
                token_next = pppenc_pkg::T_IDLE;
            end
        end
    end

    // Outputs.
    always_comb
    begin
        cmd_pop             = load && !cmd_empty;
        out_push            = advance;
        out_data.end_of_run = !first_half && last_tok;
        if (first_half)
        begin
            out_data.line_byte = pppenc_pkg::ESC_BYTE;
        end
        else if (esc_reg)
        begin
            out_data.line_byte = cur_byte ^ pppenc_pkg::ESC_XOR;
        end
        else
        begin
            out_data.line_byte = cur_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= pppenc_pkg::T_IDLE;
            esc_reg   <= 1'b0;
            crc_reg   <= pppenc_pkg::CRC_INIT;
        end
        else
        begin
            token_reg <= token_next;
            esc_reg   <= esc_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

>>> hdl/ppp_hdlc_frame_encoder_top.sv
// A request taken into an idle encoder passes the request queue, the back end's token register
// and the result queue before its first line byte shows. The back end emits one line byte per
// cycle while the result queue has room; an escaped byte is sent as 0x7D and then byte ^ 0x20.
// The back end's byte sequencer sets the rate; a four-entry request queue sits before it.
// Reset is asynchronous and active low; it empties both queues, closes any open frame and
// returns the FCS register to all ones.
module ppp_hdlc_frame_encoder_top #(
    parameter int CMD_DEPTH = pppenc_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = pppenc_pkg::OUT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  payload_byte,
    input  logic [15:0] protocol,
    input  logic        last_byte,
    input  logic        empty_frame,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  line_byte,
    output logic        end_of_run
);

    pppenc_pkg::cmd_t cmd_in;
    pppenc_pkg::cmd_t cmd_out;
    pppenc_pkg::out_t out_in;
    pppenc_pkg::out_t out_out;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_empty;
    logic             out_push;
    logic             out_full;

    pppenc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .payload_byte (payload_byte),
        .protocol     (protocol),
        .last_byte    (last_byte),
        .empty_frame  (empty_frame),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    pppenc_fifo #(
        .WIDTH ($bits(pppenc_pkg::cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    pppenc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_in)
    );

    pppenc_fifo #(
        .WIDTH ($bits(pppenc_pkg::out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_in),
        .full    (out_full),
        .pop     (pop),
        .rd_data (out_out),
        .empty   (empty)
    );

    assign full       = cmd_full;
    assign line_byte  = out_out.line_byte;
    assign end_of_run = out_out.end_of_run;

    a_cmd_pop_nonempty: assert property (
        @(posedge clk) disable iff (!rst_n) cmd_pop |-> !cmd_empty
    ) else $error("request queue read while empty");

    a_out_push_room: assert property (
        @(posedge clk) disable iff (!rst_n) out_push |-> !out_full
    ) else $error("result queue written while full");

    a_escape_not_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_push && out_in.line_byte == pppenc_pkg::ESC_BYTE) |-> !out_in.end_of_run
    ) else $error("escape byte ends a run");

    a_escape_followed: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_push && out_in.line_byte == pppenc_pkg::ESC_BYTE) |=>
            (out_in.line_byte != pppenc_pkg::ESC_BYTE && out_in.line_byte != pppenc_pkg::FLAG_BYTE)
    ) else $error("escape byte followed by escape or flag");

endmodule
